>>> rtl/tbc_pkg.sv
// Package for the triangle barycentric coordinate block.
// Item types, widths and constants; no dependencies.
package tbc_pkg;
   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 16;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * DIFF_BITS;
   localparam int AREA_BITS  = PROD_BITS + 1;
   localparam int MAG_BITS   = AREA_BITS;
   localparam int QUO_BITS   = MAG_BITS + FRAC_BITS;
   localparam int NCELLS     = QUO_BITS;

   typedef struct packed {
      logic signed [15:0] vertex0_x;
      logic signed [15:0] vertex0_y;
      logic signed [15:0] vertex1_x;
      logic signed [15:0] vertex1_y;
      logic signed [15:0] vertex2_x;
      logic signed [15:0] vertex2_y;
      logic signed [15:0] point_x;
      logic signed [15:0] point_y;
   } req_type;

   typedef struct packed {
      logic signed [31:0] weight_first;
      logic signed [31:0] weight_second;
      logic               degenerate;
   } rsp_type;

   // One lane of the divider chain.
   typedef struct packed {
      logic [MAG_BITS-1:0] rem;
      logic [QUO_BITS-1:0] num;
      logic [QUO_BITS-1:0] quo;
      logic                neg;
      logic                zero;
   } lane_type;

   typedef struct packed {
      logic                valid;
      logic                degenerate;
      logic [MAG_BITS-1:0] den;
      lane_type            l0;
      lane_type            l1;
   } cell_type;
endpackage

>>> rtl/tbc_front.sv
// Front stages: differences, cross products, areas, magnitudes.
// Depends on tbc_pkg.
module tbc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  tbc_pkg::req_type  in_item,
   output tbc_pkg::cell_type out_cell
);
   typedef logic signed [tbc_pkg::DIFF_BITS-1:0] diff_type;
   typedef logic signed [tbc_pkg::PROD_BITS-1:0] prod_type;
   typedef logic signed [tbc_pkg::AREA_BITS-1:0] area_type;

   diff_type d_in [12];
   diff_type d_ff [12];
   logic     v1_ff, v2_ff;
   prod_type p_in [6];
   prod_type p_ff [6];
   logic signed [tbc_pkg::COORD_BITS-1:0] c [8];

   function automatic logic [tbc_pkg::MAG_BITS-1:0] mag_of(input area_type a);
      return a[tbc_pkg::AREA_BITS-1] ? tbc_pkg::MAG_BITS'(-a) : tbc_pkg::MAG_BITS'(a);
   endfunction

   function automatic diff_type sub(input logic signed [tbc_pkg::COORD_BITS-1:0] a,
                                    input logic signed [tbc_pkg::COORD_BITS-1:0] b);
      return diff_type'(a) - diff_type'(b);
   endfunction

   area_type a_a, a_0, a_1;

   always_comb begin
      c[0] = in_item.vertex0_x[tbc_pkg::COORD_BITS-1:0];
      c[1] = in_item.vertex0_y[tbc_pkg::COORD_BITS-1:0];
      c[2] = in_item.vertex1_x[tbc_pkg::COORD_BITS-1:0];
      c[3] = in_item.vertex1_y[tbc_pkg::COORD_BITS-1:0];
      c[4] = in_item.vertex2_x[tbc_pkg::COORD_BITS-1:0];
      c[5] = in_item.vertex2_y[tbc_pkg::COORD_BITS-1:0];
      c[6] = in_item.point_x[tbc_pkg::COORD_BITS-1:0];
      c[7] = in_item.point_y[tbc_pkg::COORD_BITS-1:0];
      // area: (x1-x0)(y2-y0) - (x2-x0)(y1-y0)
      d_in[0]  = sub(c[2], c[0]); d_in[1]  = sub(c[5], c[1]);
      d_in[2]  = sub(c[4], c[0]); d_in[3]  = sub(c[3], c[1]);
      // n0: (x1-px)(y2-py) - (x2-px)(y1-py)
      d_in[4]  = sub(c[2], c[6]); d_in[5]  = sub(c[5], c[7]);
      d_in[6]  = sub(c[4], c[6]); d_in[7]  = sub(c[3], c[7]);
      // n1: (x2-px)(y0-py) - (x0-px)(y2-py)
      d_in[8]  = sub(c[4], c[6]); d_in[9]  = sub(c[1], c[7]);
      d_in[10] = sub(c[0], c[6]); d_in[11] = sub(c[5], c[7]);
      for (int i = 0; i < 6; i++) begin
         p_in[i] = prod_type'(d_ff[2*i]) * prod_type'(d_ff[2*i+1]);
      end
      a_a = area_type'(p_ff[0]) - area_type'(p_ff[1]);
      a_0 = area_type'(p_ff[2]) - area_type'(p_ff[3]);
      a_1 = area_type'(p_ff[4]) - area_type'(p_ff[5]);
   end

   always_ff @(posedge clock) begin
      d_ff <= d_in;
      p_ff <= p_in;
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         out_cell.valid <= 1'b0;
      end else begin
         v1_ff        <= in_valid;
         v2_ff        <= v1_ff;
         out_cell.valid <= v2_ff;
      end
      out_cell.degenerate <= (a_a == '0);
      out_cell.den        <= mag_of(a_a);
      out_cell.l0.rem  <= '0;
      out_cell.l0.quo  <= '0;
      out_cell.l0.num  <= {mag_of(a_0), {tbc_pkg::FRAC_BITS{1'b0}}};
      out_cell.l0.neg  <= a_0[tbc_pkg::AREA_BITS-1] ^ a_a[tbc_pkg::AREA_BITS-1];
      out_cell.l0.zero <= (a_0 == '0);
      out_cell.l1.rem  <= '0;
      out_cell.l1.quo  <= '0;
      out_cell.l1.num  <= {mag_of(a_1), {tbc_pkg::FRAC_BITS{1'b0}}};
      out_cell.l1.neg  <= a_1[tbc_pkg::AREA_BITS-1] ^ a_a[tbc_pkg::AREA_BITS-1];
      out_cell.l1.zero <= (a_1 == '0);
   end
endmodule

>>> rtl/tbc_cell.sv
// One restoring-division cell: one quotient bit per lane per cycle.
// Depends on tbc_pkg.
module tbc_cell (
   input  logic              clock,
   input  logic              reset,
   input  tbc_pkg::cell_type in_cell,
   output tbc_pkg::cell_type out_cell
);
   function automatic tbc_pkg::lane_type step(input tbc_pkg::lane_type l,
                                               input logic [tbc_pkg::MAG_BITS-1:0] d);
      tbc_pkg::lane_type   o;
      logic [tbc_pkg::MAG_BITS:0] t;
      o = l;
      t = {l.rem, l.num[tbc_pkg::QUO_BITS-1]};
      o.num = {l.num[tbc_pkg::QUO_BITS-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
         t = t - {1'b0, d};
         o.quo = {l.quo[tbc_pkg::QUO_BITS-2:0], 1'b1};
      end else begin
         o.quo = {l.quo[tbc_pkg::QUO_BITS-2:0], 1'b0};
      end
      o.rem = t[tbc_pkg::MAG_BITS-1:0];
      return o;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) out_cell.valid <= 1'b0;
      else       out_cell.valid <= in_cell.valid;
      out_cell.degenerate <= in_cell.degenerate;
      out_cell.den        <= in_cell.den;
      out_cell.l0         <= step(in_cell.l0, in_cell.den);
      out_cell.l1         <= step(in_cell.l1, in_cell.den);
   end
endmodule

>>> rtl/triangle_barycentric_coords.sv
// Top level of the triangle barycentric coordinate block.
// Depends on tbc_pkg, tbc_front and tbc_cell.
//
//   channel  ports                       handshake
//   input    req_item                    start & !busy
//   result   rsp_item                    rsp_strobe, one cycle
//
// One item per cycle through three front stages, one divider cell per
// quotient bit and one output stage. busy is always low. Synchronous
// reset empties the pipeline; results cannot be stalled.
module triangle_barycentric_coords (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tbc_pkg::req_type req_item,
   output logic             rsp_strobe,
   output tbc_pkg::rsp_type rsp_item
);
   tbc_pkg::cell_type chain [tbc_pkg::NCELLS+1];

   assign busy = 1'b0;

   tbc_front u_front (
      .clock(clock), .reset(reset), .in_valid(start & ~busy),
      .in_item(req_item), .out_cell(chain[0])
   );

   for (genvar g = 0; g < tbc_pkg::NCELLS; g++) begin : g_cell
      tbc_cell u_cell (.clock(clock), .reset(reset), .in_cell(chain[g]),
                       .out_cell(chain[g+1]));
   end

   function automatic logic [31:0] finish(input tbc_pkg::lane_type l);
      logic big;
      logic [31:0] m;
      big = (l.quo[tbc_pkg::QUO_BITS-1:32] != '0);
      m   = l.quo[31:0];
      if (l.zero)      return 32'h0;
      if (l.neg) begin
         if (big || m[31]) return 32'h8000_0000;
         return 32'(-m);
      end
      if (big || m[31]) return 32'h7FFF_FFFF;
      return m;
   endfunction

   tbc_pkg::cell_type last;
   assign last = chain[tbc_pkg::NCELLS];

   always_ff @(posedge clock) begin
      if (reset) rsp_strobe <= 1'b0;
      else       rsp_strobe <= last.valid;
      rsp_item.degenerate    <= last.degenerate;
      rsp_item.weight_first  <= last.degenerate ? 32'h0 : finish(last.l0);
      rsp_item.weight_second <= last.degenerate ? 32'h0 : finish(last.l1);
   end

`ifndef SYNTHESIS
   a_busy_low: assert property (@(posedge clock) !busy)
      else $error("busy raised");
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.degenerate |->
         rsp_item.weight_first == 0 && rsp_item.weight_second == 0)
      else $error("degenerate item with nonzero weight");
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !last.valid |=> !rsp_strobe)
      else $error("strobe without item");
`endif
endmodule

>>> verif/triangle_barycentric_coords_test.sv
// Testbench for triangle_barycentric_coords: directed and random triangle queries.
// Predicts the barycentric weights in the testbench and checks every item; needs tbc_pkg.
module triangle_barycentric_coords_test;

   localparam int LATENCY = 4 + tbc_pkg::QUO_BITS;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   tbc_pkg::req_type req_item = '0;
   logic             rsp_strobe;
   tbc_pkg::rsp_type rsp_item;

   tbc_pkg::rsp_type weights_due[$];
   int      failures = 0;
   int      items_sent = 0;
   int      degenerate_seen = 0;
   int      saturated_seen = 0;

   triangle_barycentric_coords dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic longint coord(logic [15:0] raw);
      logic signed [tbc_pkg::COORD_BITS-1:0] v;
      v = raw[tbc_pkg::COORD_BITS-1:0];
      return longint'(v);
   endfunction

   function automatic logic [31:0] q16_quotient(longint num, longint den);
      logic           neg;
      logic [63:0]    n, d, q, r, mag;
      neg = (num < 0) != (den < 0);
      n = (num < 0) ? -num : num;
      d = (den < 0) ? -den : den;
      q = n / d;
      r = n % d;
      if (q > (64'd1 << (32 - tbc_pkg::FRAC_BITS))) begin
         mag = 64'd1 << 32;
      end else begin
         mag = q;
         for (int i = 0; i < tbc_pkg::FRAC_BITS; i++) begin
            r = r << 1;
            mag = mag << 1;
            if (r >= d) begin
               r = r - d;
               mag[0] = 1'b1;
            end
         end
      end
      if (n == 0) return 32'h0;
      if (neg) begin
         if (mag >= 64'h8000_0000) return 32'h8000_0000;
         return 32'(64'd0 - mag);
      end
      if (mag > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
      return mag[31:0];
   endfunction

   function automatic tbc_pkg::rsp_type barycentric(tbc_pkg::req_type t);
      longint  x0, y0, x1, y1, x2, y2, px, py, area, n0, n1;
      tbc_pkg::rsp_type w;
      x0 = coord(t.vertex0_x); y0 = coord(t.vertex0_y);
      x1 = coord(t.vertex1_x); y1 = coord(t.vertex1_y);
      x2 = coord(t.vertex2_x); y2 = coord(t.vertex2_y);
      px = coord(t.point_x);   py = coord(t.point_y);
      area = (x1 - x0) * (y2 - y0) - (x2 - x0) * (y1 - y0);
      n0 = (x1 - px) * (y2 - py) - (x2 - px) * (y1 - py);
      n1 = (x2 - px) * (y0 - py) - (x0 - px) * (y2 - py);
      w = '0;
      if (area == 0) begin
         w.degenerate = 1'b1;
      end else begin
         w.weight_first  = q16_quotient(n0, area);
         w.weight_second = q16_quotient(n1, area);
      end
      return w;
   endfunction

   task automatic send_item(tbc_pkg::req_type t);
      int gap;
      gap = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_item <= t;
      @(posedge clock);
      while (busy) @(posedge clock);
      weights_due.push_back(barycentric(t));
      items_sent++;
      @(negedge clock);
   endtask

   task automatic go_idle();
      start <= 1'b0;
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      tbc_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (weights_due.size() == 0) begin
            $error("result with nothing expected");
            failures++;
         end else begin
            want = weights_due.pop_front();
            if (want.degenerate) degenerate_seen++;
            if (want.weight_first == 32'h7FFF_FFFF || want.weight_first == 32'h8000_0000)
               saturated_seen++;
            if (rsp_item.weight_first !== want.weight_first) begin
               $error("weight_first expected %h got %h", want.weight_first,
                      rsp_item.weight_first);
               failures++;
            end
            if (rsp_item.weight_second !== want.weight_second) begin
               $error("weight_second expected %h got %h", want.weight_second,
                      rsp_item.weight_second);
               failures++;
            end
            if (rsp_item.degenerate !== want.degenerate) begin
               $error("degenerate expected %b got %b", want.degenerate,
                      rsp_item.degenerate);
               failures++;
            end
         end
      end
   end

   function automatic tbc_pkg::req_type tri_of(int a, int b, int c, int d, int e, int f,
                                                int g, int h);
      tbc_pkg::req_type t;
      t.vertex0_x = 16'(a); t.vertex0_y = 16'(b);
      t.vertex1_x = 16'(c); t.vertex1_y = 16'(d);
      t.vertex2_x = 16'(e); t.vertex2_y = 16'(f);
      t.point_x   = 16'(g); t.point_y   = 16'(h);
      return t;
   endfunction

   task automatic test_directed();
      send_item(tri_of(0, 0, 1, 0, 0, 1, 0, 0));
      send_item(tri_of(0, 0, 3, 0, 0, 3, 1, 1));
      send_item(tri_of(0, 0, 3, 0, 0, 3, -1, 2));
      send_item(tri_of(0, 0, 0, 0, 0, 0, 5, 5));
      send_item(tri_of(0, 0, 1, 1, 2, 2, 7, -3));
      send_item(tri_of(0, 0, 1, 0, 0, 1, 32767, 32767));
      send_item(tri_of(0, 0, 1, 0, 0, 1, -32768, -32768));
      send_item(tri_of(0, 0, 1, 0, 0, 1, 32767, -32768));
      send_item(tri_of(-32768, -32768, 32767, -32768, -32768, 32767, 0, 0));
      send_item(tri_of(32767, 32767, -32768, 32767, 32767, -32768, -32768, -32768));
      send_item(tri_of(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
      send_item(tri_of(0, 0, 0, 1, 1, 0, 0, 0));
      send_item(tri_of(0, 0, 7, 0, 0, 3, 1, 1));
      send_item(tri_of(0, 0, 7, 0, 0, 3, -1, -1));
      send_item(tri_of(0, 0, 2, 0, 0, 2, 0, 4));
      send_item(tri_of(0, 0, 1, 0, 0, 1, 16, -1));
      send_item(tri_of(0, 0, 1, 0, 0, 1, 0, 17));
      send_item(tri_of(-1, -1, -1, -1, -1, -1, -1, -1));
      go_idle();
   endtask

   task automatic test_random();
      tbc_pkg::req_type t;
      int      mode;
      int      span;
      int      cx, cy;
      repeat (1150) begin
         mode = $urandom_range(0, 9);
         t = tbc_pkg::req_type'({$urandom, $urandom, $urandom, $urandom});
         if (mode < 4) begin
            span = 1 << $urandom_range(1, 14);
            cx = $urandom_range(0, 65535) - 32768;
            cy = $urandom_range(0, 65535) - 32768;
            cx = cx / 2; cy = cy / 2;
            t.vertex0_x = 16'(cx + $urandom_range(0, span) - span / 2);
            t.vertex0_y = 16'(cy + $urandom_range(0, span) - span / 2);
            t.vertex1_x = 16'(cx + $urandom_range(0, span) - span / 2);
            t.vertex1_y = 16'(cy + $urandom_range(0, span) - span / 2);
            t.vertex2_x = 16'(cx + $urandom_range(0, span) - span / 2);
            t.vertex2_y = 16'(cy + $urandom_range(0, span) - span / 2);
            t.point_x   = 16'(cx + $urandom_range(0, 2 * span) - span);
            t.point_y   = 16'(cy + $urandom_range(0, 2 * span) - span);
         end else if (mode == 4) begin
            // collinear or coincident vertices
            t.vertex1_x = t.vertex0_x; t.vertex1_y = t.vertex0_y;
            if ($urandom_range(0, 1)) begin
               t.vertex2_x = t.vertex0_x; t.vertex2_y = t.vertex0_y;
            end
         end else if (mode == 5) begin
            // tiny triangle, far point: saturation
            t.vertex1_x = 16'(t.vertex0_x + 16'sd1); t.vertex1_y = t.vertex0_y;
            t.vertex2_x = t.vertex0_x; t.vertex2_y = 16'(t.vertex0_y + 16'sd1);
         end
         send_item(t);
      end
      go_idle();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random();
      while (weights_due.size() != 0) @(negedge clock);
      repeat (LATENCY + 5) @(negedge clock);
      $display("Sent %0d triangle queries: %0d degenerate, %0d with saturated first weight.",
               items_sent, degenerate_seen, saturated_seen);
      if (failures == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end
endmodule
